@@ design/max_binary_heap_queue_core_assert.svh @@
// Assertion macros shared by the heap queue RTL.
`ifndef MAX_BINARY_HEAP_QUEUE_CORE_ASSERT_SVH
`define MAX_BINARY_HEAP_QUEUE_CORE_ASSERT_SVH

// Check a property at every rising clock edge outside reset.
`define MBHQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that one condition implies another in the next cycle.
`define MBHQ_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ design/mbhq_pkg.sv @@
// Constants and types for the binary max-heap priority queue.
`timescale 1ns / 1ps
package mbhq_pkg;

  localparam int unsigned CAPACITY      = 1024;
  localparam int unsigned ADDR_W        = $clog2(CAPACITY);
  localparam int unsigned CNT_W         = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W         = ADDR_W + 2;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned COUNT_FIELD_W = 11;
  localparam int unsigned OUT_FIELDS_W  = DATA_W + COUNT_FIELD_W + 3;
  localparam int unsigned OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_UP_RD   = 8'b0000_0010,
    ST_UP_CMP  = 8'b0000_0100,
    ST_DN_LAST = 8'b0000_1000,
    ST_DN_RD   = 8'b0001_0000,
    ST_DN_CMP  = 8'b0010_0000,
    ST_FIN     = 8'b0100_0000,
    ST_DONE    = 8'b1000_0000
  } state_e;

endpackage

@@ design/max_binary_heap_queue_core.sv @@
// Binary max-heap priority queue top level.
//
// Input channel s_axis: tuser carries the opcode (push or pop), tdata the
// signed 32-bit value to push (ignored on pop). One word is taken at a time:
// s_axis_tready_o is high only while no operation is in progress.
// Output channel m_axis: one word per input word with the new maximum, the
// entry count and the empty, full and error flags. A push on a full queue or
// a pop on an empty one leaves the heap unchanged and sets the error flag.
// The heap lives in one 1024 x 32 synchronous memory with a registered read.
// A push sifts up one level at a time (parent read, then compare and move);
// a pop reads the last entry, then sifts down one level at a time
// (both children read in the same cycle on two read ports, then compare and move).
// A rejected word goes straight to its result; a pop that empties the queue
// goes there once the last entry is read. The next word can be taken as
// soon as the result of the last one is in the output register.
// Reset clears the count and the control state; the memory needs no clearing
// since only entries below the count are used. The result sits in an output
// register, so a stalled receiver holds back only the next operation's finish.
`timescale 1ns / 1ps
module max_binary_heap_queue_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [31:0]                    s_axis_tdata_i,  // value[31:0]
  input  logic                           s_axis_tuser_i,  // opcode[0]
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // top_value[31:0], entry_count[42:32], is_empty[43], is_full[44],
  // op_error[45], zero pad[47:46]
  output logic [mbhq_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import mbhq_pkg::*;

  `include "max_binary_heap_queue_core_assert.svh"

  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rd_a_q, rd_b_q;
  logic                     re_a, re_b, we;
  logic [ADDR_W-1:0]        raddr_a, raddr_b, waddr;
  logic signed [DATA_W-1:0] wdata;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [ADDR_W-1:0]        pos_q, pos_d;
  logic signed [DATA_W-1:0] cur_q, cur_d;
  logic signed [DATA_W-1:0] root_q;
  logic                     err_q, err_d;
  logic                     out_valid_q;
  logic [OUT_TDATA_W-1:0]   out_data_q;

  logic                     s_acc, out_free, is_full_now;
  logic [IDX_W-1:0]         l_idx, r_idx, cnt_ext;
  logic [ADDR_W-1:0]        parent;
  logic                     r_ok, pick_r;
  logic signed [DATA_W-1:0] pick_val;
  logic [ADDR_W-1:0]        pick_idx;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign is_full_now     = (count_q == CNT_W'(CAPACITY));

  assign cnt_ext  = IDX_W'(count_q);
  assign l_idx    = IDX_W'({pos_q, 1'b1});
  assign r_idx    = l_idx + IDX_W'(1);
  assign parent   = ADDR_W'((pos_q - ADDR_W'(1)) >> 1);
  assign r_ok     = (r_idx < cnt_ext);
  assign pick_r   = r_ok && (rd_a_q < rd_b_q);
  assign pick_val = pick_r ? rd_b_q : rd_a_q;
  assign pick_idx = pick_r ? r_idx[ADDR_W-1:0] : l_idx[ADDR_W-1:0];

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    pos_d   = pos_q;
    cur_d   = cur_q;
    err_d   = err_q;
    re_a    = 1'b0;
    re_b    = 1'b0;
    raddr_a = '0;
    raddr_b = '0;
    we      = 1'b0;
    waddr   = pos_q;
    wdata   = cur_q;
    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          err_d = 1'b0;
          if (s_axis_tuser_i == OP_PUSH) begin
            if (is_full_now) begin
              err_d   = 1'b1;
              state_d = ST_DONE;
            end else begin
              pos_d   = ADDR_W'(count_q);
              cur_d   = s_axis_tdata_i;
              count_d = count_q + CNT_W'(1);
              state_d = ST_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              err_d   = 1'b1;
              state_d = ST_DONE;
            end else begin
              // fetch the last entry, it refills the root
              count_d = count_q - CNT_W'(1);
              re_a    = 1'b1;
              raddr_a = ADDR_W'(count_q - CNT_W'(1));
              state_d = ST_DN_LAST;
            end
          end
        end
      end
      ST_UP_RD: begin
        if (pos_q == '0) begin
          state_d = ST_FIN;
        end else begin
          re_a    = 1'b1;
          raddr_a = parent;
          state_d = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        if (cur_q < rd_a_q) begin
          state_d = ST_FIN;
        end else begin
          // move the parent down into the hole
          we      = 1'b1;
          waddr   = pos_q;
          wdata   = rd_a_q;
          pos_d   = parent;
          state_d = ST_UP_RD;
        end
      end
      ST_DN_LAST: begin
        cur_d = rd_a_q;
        pos_d = '0;
        if (count_q == '0) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_DN_RD;
        end
      end
      ST_DN_RD: begin
        if (l_idx >= cnt_ext) begin
          state_d = ST_FIN;
        end else begin
          re_a    = 1'b1;
          re_b    = 1'b1;
          raddr_a = l_idx[ADDR_W-1:0];
          raddr_b = r_idx[ADDR_W-1:0];
          state_d = ST_DN_CMP;
        end
      end
      ST_DN_CMP: begin
        if (cur_q < pick_val) begin
          // move the larger child up into the hole
          we      = 1'b1;
          waddr   = pos_q;
          wdata   = pick_val;
          pos_d   = pick_idx;
          state_d = ST_DN_RD;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        we      = 1'b1;
        waddr   = pos_q;
        wdata   = cur_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rd_a_q <= mem[raddr_a];
    end
    if (re_b) begin
      rd_b_q <= mem[raddr_b];
    end
  end

  // root mirror and working registers
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    cur_q <= cur_d;
    if (we && waddr == '0) begin
      root_q <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      err_q   <= err_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_data_q <= OUT_TDATA_W'({err_q,
                                  is_full_now,
                                  (count_q == '0),
                                  COUNT_FIELD_W'(count_q),
                                  (count_q != '0) ? root_q : '0});
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `MBHQ_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "count above capacity")
  `MBHQ_ASSERT_NEXT(a_count_hold, !s_acc, $stable(count_q), "count moved without a word")
  `MBHQ_ASSERT(a_no_idle_write, we |-> !(state_q == ST_IDLE || state_q == ST_DONE),
               "memory write outside an operation")
  `MBHQ_ASSERT(a_empty_top, (m_axis_tvalid_o && m_axis_tdata_o[DATA_W+COUNT_FIELD_W])
               |-> (m_axis_tdata_o[DATA_W-1:0] == '0), "empty result with nonzero top")

endmodule
